// File: src/bracket_balance_checker_assert.svh
// assertion macros shared by the bracket balance checker modules
// no dependencies; included by modules that check their own logic
`ifndef BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define BBC_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// consequence that must hold in the same cycle as the antecedent
`define BBC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define BBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bbc_pkg.sv
// shared types, sizes and codes of the bracket balance checker
// no dependencies; imported by every module of the block
package bbc_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int POS_W       = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // bracket characters
    localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

    // bracket kinds
    localparam logic [1:0] KIND_PAREN  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;

    // byte classes
    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_OPEN  = 2'd1;
    localparam logic [1:0] CLS_CLOSE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_BALANCED = 2'd0;
    localparam logic [1:0] ST_BAD_CLOSE = 2'd1;
    localparam logic [1:0] ST_UNCLOSED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // classified item passed from the front end to the stack engine
    typedef struct packed {
        logic [1:0]       cls;
        logic [1:0]       kind;
        logic [POS_W-1:0] pos;
        logic             last;
    } bbc_item_t;

    // one stack entry
    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] where;
    } bbc_entry_t;

endpackage

// File: src/bbc_front.sv
// front end: classifies each byte and numbers it within its text
// depends on bbc_pkg
module bbc_front
    import bbc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_char,
    input  logic       in_last,
    input  logic       item_ready,
    output logic       item_valid,
    output bbc_item_t  item
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_inc;
    logic             take;

    assign take       = in_valid && item_ready;
    assign item_valid = in_valid;

    // saturating position count
    assign pos_inc = (pos_reg == {POS_W{1'b1}}) ? pos_reg : pos_reg + POS_W'(1);

    always_comb begin
        item.pos  = pos_inc;
        item.last = in_last;
        item.cls  = CLS_OTHER;
        item.kind = KIND_PAREN;
        unique case (in_char)
            CH_OPEN_PAREN: begin
                item.cls  = CLS_OPEN;
                item.kind = KIND_PAREN;
            end
            CH_OPEN_SQUARE: begin
                item.cls  = CLS_OPEN;
                item.kind = KIND_SQUARE;
            end
            CH_OPEN_CURLY: begin
                item.cls  = CLS_OPEN;
                item.kind = KIND_CURLY;
            end
            CH_CLOSE_PAREN: begin
                item.cls  = CLS_CLOSE;
                item.kind = KIND_PAREN;
            end
            CH_CLOSE_SQUARE: begin
                item.cls  = CLS_CLOSE;
                item.kind = KIND_SQUARE;
            end
            CH_CLOSE_CURLY: begin
                item.cls  = CLS_CLOSE;
                item.kind = KIND_CURLY;
            end
            default: begin
                item.cls  = CLS_OTHER;
                item.kind = KIND_PAREN;
            end
        endcase
    end

    always_comb begin
        pos_next = pos_reg;
        if (take) begin
            pos_next = in_last ? '0 : pos_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

// File: src/bbc_queue.sv
// two-entry queue between the front end and the stack engine
// depends on bbc_pkg
module bbc_queue
    import bbc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    input  bbc_item_t wr_item,
    output logic      wr_ready,
    output logic      rd_valid,
    output bbc_item_t rd_item,
    input  logic      rd_ready
);

    bbc_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;

    assign wr_ready = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: src/bbc_stack.sv
// stack engine: pushes and pops brackets, latches the first error, gives the result
// depends on bbc_pkg and bracket_balance_checker_assert.svh
`include "bracket_balance_checker_assert.svh"

module bbc_stack
    import bbc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  bbc_item_t        item,
    output logic             item_ready,
    output logic             res_valid,
    output logic [1:0]       res_status,
    output logic [POS_W-1:0] res_where,
    input  logic             res_ready
);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

    // entries below the top live in memory; the top sits in a register
    bbc_entry_t       mem [STACK_DEPTH];
    bbc_entry_t       rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    bbc_entry_t       top_reg;
    bbc_entry_t       top_next;
    bbc_entry_t       byp_reg;
    bbc_entry_t       byp_next;
    logic             byp_sel_reg;
    logic             byp_sel_next;
    bbc_entry_t       below;
    logic [1:0]       err_reg;
    logic [1:0]       err_next;
    logic [POS_W-1:0] err_where_reg;
    logic [POS_W-1:0] err_where_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [1:0]       out_status_reg;
    logic [1:0]       out_status_next;
    logic [POS_W-1:0] out_where_reg;
    logic [POS_W-1:0] out_where_next;
    logic             take;
    logic [CNT_W-1:0] count_live;

    assign item_ready = !out_valid_reg || res_ready;
    assign take       = item_valid && item_ready;
    assign res_valid  = out_valid_reg;
    assign res_status = out_status_reg;
    assign res_where  = out_where_reg;

    // entry just under the top: freshly pushed value or the memory read
    assign below = byp_sel_reg ? byp_reg : rd_data_reg;

    always_comb begin
        count_live      = count_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        byp_next        = byp_reg;
        byp_sel_next    = byp_sel_reg;
        err_next        = err_reg;
        err_where_next  = err_where_reg;
        wr_en           = 1'b0;
        wr_addr         = ADDR_W'(count_reg - CNT_W'(1));
        out_valid_next  = out_valid_reg && !res_ready;
        out_status_next = out_status_reg;
        out_where_next  = out_where_reg;
        if (take) begin
            if (err_reg == ST_BALANCED) begin
                case (item.cls)
                    CLS_OPEN: begin
                        if (count_reg == FULL_COUNT) begin
                            err_next       = ST_OVERFLOW;
                            err_where_next = item.pos;
                        end else begin
                            wr_en        = (count_reg != '0);
                            top_next     = '{kind: item.kind, where: item.pos};
                            byp_next     = top_reg;
                            byp_sel_next = 1'b1;
                            count_live   = count_reg + CNT_W'(1);
                        end
                    end
                    CLS_CLOSE: begin
                        if (count_reg == '0) begin
                            err_next       = ST_BAD_CLOSE;
                            err_where_next = item.pos;
                        end else begin
                            top_next     = below;
                            byp_sel_next = 1'b0;
                            count_live   = count_reg - CNT_W'(1);
                            if (top_reg.kind != item.kind) begin
                                err_next       = ST_BAD_CLOSE;
                                err_where_next = item.pos;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            count_next = count_live;
            if (item.last) begin
                out_valid_next = 1'b1;
                if (err_next != ST_BALANCED) begin
                    out_status_next = err_next;
                    out_where_next  = err_where_next;
                end else if (count_live != '0) begin
                    out_status_next = ST_UNCLOSED;
                    out_where_next  = top_next.where;
                end else begin
                    out_status_next = ST_BALANCED;
                    out_where_next  = '0;
                end
                count_next     = '0;
                err_next       = ST_BALANCED;
                err_where_next = '0;
            end
        end
    end

    // keep the memory read aimed at the entry under the next top
    assign rd_addr = ADDR_W'(count_next - CNT_W'(2));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= top_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            byp_sel_reg   <= 1'b0;
            err_reg       <= ST_BALANCED;
            err_where_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            byp_sel_reg   <= byp_sel_next;
            err_reg       <= err_next;
            err_where_reg <= err_where_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg        <= top_next;
        byp_reg        <= byp_next;
        out_status_reg <= out_status_next;
        out_where_reg  <= out_where_next;
    end

    `BBC_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= FULL_COUNT, "stack count past depth")
    `BBC_ASSERT_SAME(a_balanced_zero, aclk, aresetn, out_valid_reg && (out_status_reg == ST_BALANCED), out_where_reg == '0, "balanced result with nonzero position")
    `BBC_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, take && item.last, (count_reg == '0) && (err_reg == ST_BALANCED) && out_valid_reg, "state not cleared after last item")

endmodule

// File: src/bracket_balance_checker.sv
// bracket balance checker: one text byte per item on the s_ side; for each text
// (closed by s_tlast) one result on the m_ side. rate is one item per clock while
// m_tready does not stall the result, held end to end: the front end numbers and
// classifies bytes, a two-entry queue decouples it from the stack engine, and the
// stack engine does at most one push or one pop per cycle. the stack keeps its top
// entry in a register and the entry below in a bypass register or a registered
// read of a single-port-write memory of 1024 entries, so a pop never waits on the
// memory. the last byte of a text passes through a queue slot, and the result is
// then registered in the stack engine before it is offered on the m_ side.
// the stack memory needs no clearing pass after reset, so items are taken at once.
// depends on bbc_pkg, bbc_front, bbc_queue and bbc_stack
module bracket_balance_checker
    import bbc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input item channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_in
    input  logic        s_tlast,    // last byte of the text
    // result item channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // [1:0] status, [17:2] error_position, rest zero
);

    // front end to queue
    logic      fr_valid;
    logic      fr_ready;
    bbc_item_t fr_item;

    // queue to stack engine
    logic      q_valid;
    logic      q_ready;
    bbc_item_t q_item;

    // result from stack engine
    logic [1:0]       res_status;
    logic [POS_W-1:0] res_where;

    bbc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .item_ready (fr_ready),
        .item_valid (fr_valid),
        .item       (fr_item)
    );

    assign s_tready = fr_ready;

    bbc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_item  (fr_item),
        .wr_ready (fr_ready),
        .rd_valid (q_valid),
        .rd_item  (q_item),
        .rd_ready (q_ready)
    );

    bbc_stack u_stack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_valid),
        .item       (q_item),
        .item_ready (q_ready),
        .res_valid  (m_tvalid),
        .res_status (res_status),
        .res_where  (res_where),
        .res_ready  (m_tready)
    );

    // pack result fields from the lowest bit up, pad to whole bytes
    assign m_tdata = {6'd0, res_where, res_status};

endmodule

// File: tb/tb.sv
// testbench of the bracket balance checker: a directed table of short texts, texts
// that fill the stack, overflow it or saturate the position count, then random texts
// depends on bbc_pkg and the bracket_balance_checker top level
`timescale 1ns / 100ps

module tb
    import bbc_pkg::*;
();

    localparam int HOLD_LIMIT   = 2000;   // cycles with no item moved on either side
    localparam int RANDOM_ITEMS = 1500;
    localparam int POS_MAX      = (1 << POS_W) - 1;
    localparam int SETTLE       = 10;

    localparam logic [7:0] OPENERS [3] = '{CH_OPEN_PAREN, CH_OPEN_SQUARE, CH_OPEN_CURLY};
    localparam logic [7:0] CLOSERS [3] = '{CH_CLOSE_PAREN, CH_CLOSE_SQUARE, CH_CLOSE_CURLY};

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] where;
    } verdict_t;

    typedef struct {
        logic [7:0]       ch;
        logic             last;
        bit               typed;    // verdict below is the expected one
        logic [1:0]       status;
        logic [POS_W-1:0] where;
    } text_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // mirror of the checker state
    logic [1:0]       open_kind  [STACK_DEPTH];
    logic [POS_W-1:0] open_where [STACK_DEPTH];
    int               open_count     = 0;
    logic [POS_W-1:0] text_pos       = '0;
    logic [1:0]       latched_status = ST_BALANCED;
    logic [POS_W-1:0] latched_where  = '0;

    verdict_t verdicts_due[$];
    bit       idle_ok      = 1'b1;
    int       failures     = 0;
    int       texts_sent   = 0;
    int       live_items   = 0;
    int       quiet_cycles = 0;
    int       status_seen [4] = '{0, 0, 0, 0};

    text_row_t directed_rows[$] = '{
        '{"x",             1'b1, 1'b1, ST_BALANCED,  16'd0},
        '{CH_CLOSE_PAREN,  1'b1, 1'b1, ST_BAD_CLOSE, 16'd1},
        '{CH_OPEN_PAREN,   1'b1, 1'b1, ST_UNCLOSED,  16'd1},
        '{CH_CLOSE_CURLY,  1'b1, 1'b1, ST_BAD_CLOSE, 16'd1},
        '{CH_OPEN_PAREN,   1'b0, 1'b0, ST_BALANCED,  16'd0},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, ST_BALANCED,  16'd0},
        '{CH_OPEN_CURLY,   1'b0, 1'b0, ST_BALANCED,  16'd0},
        '{CH_CLOSE_CURLY,  1'b0, 1'b0, ST_BALANCED,  16'd0},
        '{CH_CLOSE_SQUARE, 1'b0, 1'b0, ST_BALANCED,  16'd0},
        '{CH_CLOSE_PAREN,  1'b1, 1'b0, ST_BALANCED,  16'd0},
        '{CH_OPEN_PAREN,   1'b0, 1'b0, ST_BALANCED,  16'd0},
        '{CH_CLOSE_SQUARE, 1'b1, 1'b1, ST_BAD_CLOSE, 16'd2},
        '{CH_OPEN_CURLY,   1'b0, 1'b0, ST_BALANCED,  16'd0},
        '{CH_CLOSE_PAREN,  1'b1, 1'b1, ST_BAD_CLOSE, 16'd2},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, ST_BALANCED,  16'd0},
        '{CH_CLOSE_PAREN,  1'b0, 1'b0, ST_BALANCED,  16'd0},
        '{"x",             1'b0, 1'b0, ST_BALANCED,  16'd0},
        '{CH_OPEN_PAREN,   1'b1, 1'b1, ST_BAD_CLOSE, 16'd2},
        '{8'h00,           1'b0, 1'b0, ST_BALANCED,  16'd0},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, ST_BALANCED,  16'd0},
        '{8'hFF,           1'b1, 1'b1, ST_UNCLOSED,  16'd2}
    };

    bracket_balance_checker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // advances the mirrored state by one byte; returns 1 with the verdict on the last
    function automatic bit bracket_step(input logic [7:0] ch, input logic last,
                                        output verdict_t verdict);
        bit         opener;
        bit         closer;
        logic [1:0] kind;
        opener  = 1'b0;
        closer  = 1'b0;
        kind    = KIND_PAREN;
        verdict = '0;
        case (ch)
            CH_OPEN_PAREN:   begin opener = 1'b1; kind = KIND_PAREN;  end
            CH_OPEN_SQUARE:  begin opener = 1'b1; kind = KIND_SQUARE; end
            CH_OPEN_CURLY:   begin opener = 1'b1; kind = KIND_CURLY;  end
            CH_CLOSE_PAREN:  begin closer = 1'b1; kind = KIND_PAREN;  end
            CH_CLOSE_SQUARE: begin closer = 1'b1; kind = KIND_SQUARE; end
            CH_CLOSE_CURLY:  begin closer = 1'b1; kind = KIND_CURLY;  end
            default: ;
        endcase
        if (latched_status == ST_BALANCED) begin
            if (text_pos != POS_MAX[POS_W-1:0])
                text_pos = text_pos + 1'b1;
            if (opener) begin
                if (open_count >= STACK_DEPTH) begin
                    latched_status = ST_OVERFLOW;
                    latched_where  = text_pos;
                end else begin
                    open_kind[open_count]  = kind;
                    open_where[open_count] = text_pos;
                    open_count++;
                end
            end else if (closer) begin
                if (open_count == 0) begin
                    latched_status = ST_BAD_CLOSE;
                    latched_where  = text_pos;
                end else begin
                    open_count--;
                    if (open_kind[open_count] != kind) begin
                        latched_status = ST_BAD_CLOSE;
                        latched_where  = text_pos;
                    end
                end
            end
        end
        if (!last)
            return 1'b0;
        if (latched_status != ST_BALANCED) begin
            verdict.status = latched_status;
            verdict.where  = latched_where;
        end else if (open_count > 0) begin
            verdict.status = ST_UNCLOSED;
            verdict.where  = open_where[open_count - 1];
        end
        open_count     = 0;
        text_pos       = '0;
        latched_status = ST_BALANCED;
        latched_where  = '0;
        return 1'b1;
    endfunction

    // any byte that is not a bracket
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        case (b)
            CH_OPEN_PAREN, CH_OPEN_SQUARE, CH_OPEN_CURLY,
            CH_CLOSE_PAREN, CH_CLOSE_SQUARE, CH_CLOSE_CURLY: b = b ^ 8'h40;
            default: ;
        endcase
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] ch, input logic last,
                             input bit typed = 1'b0, input verdict_t typed_verdict = '0);
        verdict_t verdict;
        if (idle_ok && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (latched_status == ST_BALANCED)
            live_items++;
        if (bracket_step(ch, last, verdict)) begin
            verdicts_due.push_back(typed ? typed_verdict : verdict);
            texts_sent++;
        end
    endtask

    task automatic send_random_text();
        logic [7:0] body[$];
        logic [1:0] open_kinds[$];
        int         len;
        int         flavour;    // 0-5 well formed, 6-7 broken, 8-9 noise
        flavour = $urandom_range(9);
        len = ($urandom_range(19) == 0) ? $urandom_range(300, 40) : $urandom_range(24, 1);
        for (int i = 0; i < len; i++) begin
            int         pick;
            logic [1:0] k;
            pick = $urandom_range(99);
            k    = 2'($urandom_range(2));
            if (flavour >= 8)
                body.push_back(8'($urandom_range(255)));
            else if (pick < 35) begin
                body.push_back(OPENERS[k]);
                open_kinds.push_back(k);
            end else if (pick < 65 && open_kinds.size() != 0) begin
                k = open_kinds.pop_back();
                if (flavour >= 6 && $urandom_range(9) == 0)
                    k = (k == KIND_CURLY) ? KIND_PAREN : k + 2'd1;
                body.push_back(CLOSERS[k]);
            end else if (pick < 65 && flavour >= 6)
                body.push_back(CLOSERS[k]);   // stray closer on an empty stack
            else
                body.push_back(plain_byte());
        end
        // well formed texts close whatever is still open
        if (flavour < 6)
            while (open_kinds.size() != 0)
                body.push_back(CLOSERS[open_kinds.pop_back()]);
        foreach (body[i])
            send_byte(body[i], i == body.size() - 1);
    endtask

    // result side: random stalls, except in the calm stretch
    always @(posedge aclk) begin
        m_tready <= !(idle_ok && $urandom_range(99) < 7);
    end

    always @(posedge aclk) begin : result_check
        verdict_t got;
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.where  = m_tdata[17:2];
            if (verdicts_due.size() == 0) begin
                $error("result with no text pending: status %0d, error_position %0d",
                       got.status, got.where);
                failures++;
            end else begin
                want = verdicts_due.pop_front();
                status_seen[want.status]++;
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    failures++;
                end
                if (got.where !== want.where) begin
                    $error("error_position: expected %0d, actual %0d", want.where, got.where);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HOLD_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", HOLD_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : stimulus
        logic [1:0] depth_kinds[$];
        int         random_texts;
        random_texts = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                      {directed_rows[i].status, directed_rows[i].where});

        // stack filled to the last slot, then emptied in order
        for (int i = 0; i < STACK_DEPTH; i++) begin
            depth_kinds.push_back(2'($urandom_range(2)));
            send_byte(OPENERS[depth_kinds[i]], 1'b0);
        end
        for (int i = STACK_DEPTH - 1; i >= 0; i--)
            send_byte(CLOSERS[depth_kinds[i]], i == 0);

        // one opener more than the stack holds
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_byte(CH_OPEN_CURLY, 1'b0);
        send_byte(CH_CLOSE_CURLY, 1'b1, 1'b1, {ST_OVERFLOW, POS_W'(STACK_DEPTH + 1)});

        // position count pinned at its maximum before the mismatch
        for (int i = 1; i < POS_MAX; i++)
            send_byte(plain_byte(), 1'b0);
        send_byte(CH_OPEN_SQUARE, 1'b0);
        send_byte("z", 1'b0);
        send_byte(CH_OPEN_PAREN, 1'b0);
        send_byte(CH_CLOSE_SQUARE, 1'b1, 1'b1, {ST_BAD_CLOSE, POS_W'(POS_MAX)});

        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            idle_ok = !(random_texts >= 40 && random_texts < 90);
            send_random_text();
            random_texts++;
        end
        idle_ok = 1'b1;

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("%0d texts checked (%0d random), including a full stack, an overflow",
                 texts_sent, random_texts);
        $display("and a saturated position; verdicts: %0d balanced, %0d bad closer, %0d %s",
                 status_seen[ST_BALANCED], status_seen[ST_BAD_CLOSE],
                 status_seen[ST_UNCLOSED], $sformatf("unclosed, %0d overflow",
                 status_seen[ST_OVERFLOW]));
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: bracket_balance_checker.f
+incdir+src
src/bbc_pkg.sv
src/bbc_front.sv
src/bbc_queue.sv
src/bbc_stack.sv
src/bracket_balance_checker.sv
tb/tb.sv
